### src/rws_pkg.sv
// Shared constants, types and codes of the roulette wheel selector.
`timescale 1ns / 1ps

package rws_pkg;

    // Sizing
    localparam int MAX_ENTRIES  = 256;
    localparam int FITNESS_BITS = 24;
    localparam int CELL_SLOTS   = 8;
    localparam int SLOT_W       = $clog2(CELL_SLOTS);
    localparam int CELL_COUNT   = (MAX_ENTRIES + CELL_SLOTS - 1) / CELL_SLOTS;
    localparam int COUNT_W      = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W        = $clog2(MAX_ENTRIES);
    localparam int BASE_W       = $clog2(CELL_COUNT * CELL_SLOTS + 1);
    localparam int TOTAL_W      = 32;
    localparam int FRAC_W       = 16;
    localparam int REM_W        = TOTAL_W + FRAC_W;
    localparam int LP_W         = FITNESS_BITS + SLOT_W;
    localparam int CMP_W        = (REM_W > LP_W + FRAC_W) ? REM_W : LP_W + FRAC_W;
    localparam int DIV_CNT_W    = $clog2(TOTAL_W);

    // Field widths at the ports
    localparam int CODE_IO_W  = 2;
    localparam int FIT_IO_W   = 24;
    localparam int IDX_IO_W   = 8;
    localparam int COUNT_IO_W = 9;

    typedef logic [FITNESS_BITS-1:0] t_fit;
    typedef logic [LP_W-1:0]         t_lp;
    typedef logic [REM_W-1:0]        t_rem;
    typedef logic [CMP_W-1:0]        t_cmp;
    typedef logic [BASE_W-1:0]       t_base;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [COUNT_W-1:0]      t_count;
    typedef logic [TOTAL_W-1:0]      t_total;
    typedef logic [TOTAL_W:0]        t_sum;
    typedef logic [FRAC_W-1:0]       t_frac;
    typedef logic [SLOT_W-1:0]       t_slot;
    typedef logic [DIV_CNT_W-1:0]    t_div_cnt;

    typedef logic [CODE_IO_W-1:0]  t_code_io;
    typedef logic [FIT_IO_W-1:0]   t_fit_io;
    typedef logic [IDX_IO_W-1:0]   t_idx_io;
    typedef logic [COUNT_IO_W-1:0] t_count_io;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_SELECT = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    // Search token handed from cell to cell
    typedef struct packed {
        logic  valid;
        logic  found;
        t_base base;   // table index of the receiving cell's first slot
        t_rem  rem;    // portion still to be covered, scaled by 2^16
        t_idx  idx;
        t_fit  fit;
    } t_token;

    // Append write broadcast to the cells
    typedef struct packed {
        logic  en;
        t_slot slot;
        t_fit  fit;
    } t_cell_wr;

endpackage

### src/rws_ifs.sv
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps

interface rws_in_if;
    logic               valid;
    logic               ready;
    rws_pkg::t_code_io  action;
    rws_pkg::t_fit_io   fitness;
    rws_pkg::t_frac     random_fraction;

    modport source (output valid, action, fitness, random_fraction, input ready);
    modport sink   (input valid, action, fitness, random_fraction, output ready);
endinterface

interface rws_out_if;
    logic                valid;
    logic                ready;
    rws_pkg::t_code_io   status;
    rws_pkg::t_idx_io    selected_index;
    rws_pkg::t_fit_io    selected_fitness;
    rws_pkg::t_count_io  population_count;
    rws_pkg::t_total     total_fitness;
    rws_pkg::t_fit_io    worst_fitness;
    rws_pkg::t_fit_io    best_fitness;
    rws_pkg::t_fit_io    average_fitness;

    modport source (output valid, status, selected_index, selected_fitness,
                    population_count, total_fitness, worst_fitness, best_fitness,
                    average_fitness, input ready);
    modport sink   (input valid, status, selected_index, selected_fitness,
                    population_count, total_fitness, worst_fitness, best_fitness,
                    average_fitness, output ready);
endinterface

### src/roulette_wheel_selector.sv
// Top level of the roulette wheel selector: control, statistics and cell chain.
//
//   channel  dir  fields                                          accepted
//   i_in     in   action, fitness, random_fraction                valid && ready
//   o_out    out  status, selected_index, selected_fitness,       valid && ready
//                 population_count, total_fitness, worst_fitness,
//                 best_fitness, average_fitness
//
// The 32-step average divider and the walk of the search token along the
// 32 cells run side by side; for a select the token finishes later and
// sets when the item is done, for any other item the divider does.
// One item is worked at a time.
// Synchronous reset empties the table; no clearing pass is needed.
// The result register holds one item, so a new item is taken while it waits.
`timescale 1ns / 1ps

module roulette_wheel_selector (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rws_in_if.sink     i_in,
    rws_out_if.source  o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_INJECT,
        S_RUN
    } t_state;

    t_state            r_state;
    rws_pkg::t_count   r_count;
    rws_pkg::t_total   r_total;
    rws_pkg::t_fit     r_worst;
    rws_pkg::t_fit     r_best;
    rws_pkg::t_frac    r_frac;
    rws_pkg::t_status  r_status;
    logic              r_select;
    rws_pkg::t_idx     r_sel_idx;
    rws_pkg::t_fit     r_sel_fit;
    rws_pkg::t_rem     r_scaled;

    logic                r_out_valid;
    rws_pkg::t_code_io   r_out_status;
    rws_pkg::t_idx_io    r_out_idx;
    rws_pkg::t_fit_io    r_out_sel_fit;
    rws_pkg::t_count_io  r_out_count;
    rws_pkg::t_total     r_out_total;
    rws_pkg::t_fit_io    r_out_worst;
    rws_pkg::t_fit_io    r_out_best;
    rws_pkg::t_fit_io    r_out_avg;

    logic              w_accept;
    rws_pkg::t_action  w_action;
    rws_pkg::t_fit     w_fit;
    logic              w_full;
    rws_pkg::t_sum     w_sum;
    logic              w_wr_en;
    logic              w_div_busy;
    rws_pkg::t_total   w_quot;
    logic              w_done;
    rws_pkg::t_token   w_tok_head;
    rws_pkg::t_token   w_tok  [rws_pkg::CELL_COUNT];
    rws_pkg::t_cell_wr w_wr   [rws_pkg::CELL_COUNT];

    // Input decode
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_action   = rws_pkg::t_action'(i_in.action);
    assign w_fit      = rws_pkg::t_fit'(i_in.fitness);
    assign w_full     = r_count >= rws_pkg::t_count'(rws_pkg::MAX_ENTRIES);
    assign w_sum      = rws_pkg::t_sum'(r_total) + rws_pkg::t_sum'(w_fit);
    assign w_wr_en    = w_accept && (w_action == rws_pkg::ACT_APPEND) && !w_full;

    // Append write: the cell owning the next free slot
    always_comb begin
        for (int k = 0; k < rws_pkg::CELL_COUNT; k++) begin
            w_wr[k].en   = w_wr_en &&
                           ((32'(r_count) >> rws_pkg::SLOT_W) == 32'(k));
            w_wr[k].slot = rws_pkg::t_slot'(r_count);
            w_wr[k].fit  = w_fit;
        end
    end

    // Token launched into the first cell
    always_comb begin
        w_tok_head       = '0;
        w_tok_head.valid = (r_state == S_INJECT) && r_select;
        w_tok_head.rem   = r_scaled;
    end

    // Cell chain
    for (genvar k = 0; k < rws_pkg::CELL_COUNT; k++) begin : g_cell
        if (k == 0) begin : g_first
            rws_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_wr    (w_wr[k]),
                .i_count (r_count),
                .i_tok   (w_tok_head),
                .o_tok   (w_tok[k])
            );
        end else begin : g_next
            rws_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_wr    (w_wr[k]),
                .i_count (r_count),
                .i_tok   (w_tok[k-1]),
                .o_tok   (w_tok[k])
            );
        end
    end

    // Average divider, started once the state is settled
    rws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_SETUP),
        .i_dividend (r_total),
        .i_divisor  (r_count),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    assign w_done = (r_state == S_RUN) && !w_div_busy && !r_select &&
                    (!r_out_valid || o_out.ready);

    // Control, statistics and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_worst     <= '1;
            r_best      <= '0;
            r_select    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            // token leaves the last cell
            if (w_tok[rws_pkg::CELL_COUNT-1].valid) begin
                r_sel_idx <= w_tok[rws_pkg::CELL_COUNT-1].idx;
                r_sel_fit <= w_tok[rws_pkg::CELL_COUNT-1].fit;
                r_select  <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_frac    <= i_in.random_fraction;
                        r_status  <= rws_pkg::STS_OK;
                        r_select  <= 1'b0;
                        r_sel_idx <= '0;
                        r_sel_fit <= '0;
                        unique case (w_action)
                            rws_pkg::ACT_CLEAR: begin
                                r_count <= '0;
                                r_total <= '0;
                                r_worst <= '1;
                                r_best  <= '0;
                            end
                            rws_pkg::ACT_APPEND: begin
                                if (w_full) begin
                                    r_status <= rws_pkg::STS_FULL;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                    // total saturates at all ones
                                    r_total <= w_sum[rws_pkg::TOTAL_W] ? '1 :
                                               w_sum[rws_pkg::TOTAL_W-1:0];
                                    if (w_fit < r_worst) begin
                                        r_worst <= w_fit;
                                    end
                                    if (w_fit > r_best) begin
                                        r_best <= w_fit;
                                    end
                                end
                            end
                            rws_pkg::ACT_SELECT: begin
                                if (r_count == '0) begin
                                    r_status <= rws_pkg::STS_EMPTY;
                                end else begin
                                    r_select <= 1'b1;
                                end
                            end
                            rws_pkg::ACT_NOP: begin
                            end
                        endcase
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_scaled <= rws_pkg::t_rem'(r_frac) * rws_pkg::t_rem'(r_total);
                    r_state  <= S_INJECT;
                end
                S_INJECT: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (w_done) begin
                        r_out_valid   <= 1'b1;
                        r_out_status  <= rws_pkg::t_code_io'(r_status);
                        r_out_idx     <= rws_pkg::t_idx_io'(r_sel_idx);
                        r_out_sel_fit <= rws_pkg::t_fit_io'(r_sel_fit);
                        r_out_count   <= rws_pkg::t_count_io'(r_count);
                        r_out_total   <= r_total;
                        r_out_worst   <= rws_pkg::t_fit_io'(r_worst);
                        r_out_best    <= rws_pkg::t_fit_io'(r_best);
                        r_out_avg     <= (r_count == '0) ? '0 : rws_pkg::t_fit_io'(w_quot);
                        r_state       <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // Result channel
    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_out_status;
    assign o_out.selected_index   = r_out_idx;
    assign o_out.selected_fitness = r_out_sel_fit;
    assign o_out.population_count = r_out_count;
    assign o_out.total_fitness    = r_out_total;
    assign o_out.worst_fitness    = r_out_worst;
    assign o_out.best_fitness     = r_out_best;
    assign o_out.average_fitness  = r_out_avg;

endmodule

### src/rws_cell.sv
// One cell of the table chain: a block of fitness slots and one search step.
`timescale 1ns / 1ps

module rws_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rws_pkg::t_cell_wr i_wr,
    input  rws_pkg::t_count   i_count,
    input  rws_pkg::t_token   i_tok,
    output rws_pkg::t_token   o_tok
);

    rws_pkg::t_fit   r_fit [rws_pkg::CELL_SLOTS];
    rws_pkg::t_lp    r_lp  [rws_pkg::CELL_SLOTS];   // prefix sums local to the block
    rws_pkg::t_lp    r_bsum;
    rws_pkg::t_token r_tok;

    rws_pkg::t_lp                       n_lp;
    rws_pkg::t_token                    n_tok;
    logic [rws_pkg::CELL_SLOTS-1:0]     w_hit;
    rws_pkg::t_slot                     w_sel;
    logic                               w_any;

    // Local prefix of the slot being appended; slot zero opens a fresh block
    always_comb begin
        if (i_wr.slot == '0) begin
            n_lp = rws_pkg::t_lp'(i_wr.fit);
        end else begin
            n_lp = rws_pkg::t_lp'(r_bsum + rws_pkg::t_lp'(i_wr.fit));
        end
    end

    // A held slot qualifies when its prefix passes the remaining portion
    always_comb begin
        for (int j = 0; j < rws_pkg::CELL_SLOTS; j++) begin
            w_hit[j] = ((32'(i_tok.base) + 32'(j)) < 32'(i_count)) &&
                       ((rws_pkg::t_cmp'(r_lp[j]) << rws_pkg::FRAC_W) >
                        rws_pkg::t_cmp'(i_tok.rem));
        end
    end

    // First qualifying slot
    always_comb begin
        w_sel = '0;
        w_any = 1'b0;
        for (int j = rws_pkg::CELL_SLOTS - 1; j >= 0; j--) begin
            if (w_hit[j]) begin
                w_sel = rws_pkg::t_slot'(j);
                w_any = 1'b1;
            end
        end
    end

    // Next token
    always_comb begin
        n_tok      = i_tok;
        n_tok.base = rws_pkg::t_base'(32'(i_tok.base) + rws_pkg::CELL_SLOTS);
        if (!i_tok.found) begin
            if (w_any) begin
                n_tok.found = 1'b1;
                n_tok.idx   = rws_pkg::t_idx'(32'(i_tok.base) + 32'(w_sel));
                n_tok.fit   = r_fit[w_sel];
            end else begin
                // no hit anywhere falls back to entry zero
                if (i_tok.base == '0) begin
                    n_tok.fit = r_fit[0];
                end
                if (32'(i_tok.base) < 32'(i_count)) begin
                    n_tok.rem = rws_pkg::t_rem'(rws_pkg::t_cmp'(i_tok.rem) -
                                (rws_pkg::t_cmp'(r_bsum) << rws_pkg::FRAC_W));
                end
            end
        end
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_fit[i_wr.slot] <= i_wr.fit;
            r_lp[i_wr.slot]  <= n_lp;
            r_bsum           <= n_lp;
        end
    end

    // Token register towards the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

### src/rws_div.sv
// Restoring divider for the floor average, one quotient bit per cycle.
`timescale 1ns / 1ps

module rws_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rws_pkg::t_total i_dividend,
    input  rws_pkg::t_count i_divisor,
    output logic            o_busy,
    output rws_pkg::t_total o_quot
);

    logic              r_busy;
    rws_pkg::t_div_cnt r_cnt;
    rws_pkg::t_count   r_rem;
    rws_pkg::t_count   r_div;
    rws_pkg::t_total   r_quo;

    logic [rws_pkg::COUNT_W:0] w_trial;
    logic                      w_ge;
    rws_pkg::t_count           n_rem;

    // Trial subtract
    always_comb begin
        w_trial = {r_rem, r_quo[rws_pkg::TOTAL_W-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        if (w_ge) begin
            n_rem = rws_pkg::t_count'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = rws_pkg::t_count'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= rws_pkg::t_div_cnt'(rws_pkg::TOTAL_W - 1);
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_quo  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[rws_pkg::TOTAL_W-2:0], w_ge};
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

### tb/roulette_wheel_selector_tb.sv
// Self-checking testbench of the roulette wheel selector, with its own table model.
`timescale 1ns / 1ps

module roulette_wheel_selector_tb;
    import rws_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int DRAIN_CYCLES  = 80;

    typedef struct {
        t_action  action;
        t_fit_io  fitness;
        t_frac    fraction;
    } wheel_item_t;

    typedef struct {
        t_code_io   status;
        t_idx_io    index;
        t_fit_io    pick_fit;
        t_count_io  count;
        t_total     total;
        t_fit_io    worst;
        t_fit_io    best;
        t_fit_io    avg;
    } wheel_outcome_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rws_in_if  in_ch ();
    rws_out_if out_ch ();

    roulette_wheel_selector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Clock: 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Model state of the fitness table
    t_fit_io     wheel_fit [MAX_ENTRIES];
    int unsigned wheel_count = 0;
    t_total      wheel_total = '0;
    t_fit_io     wheel_worst = '1;
    t_fit_io     wheel_best  = '0;

    wheel_item_t    action_q [$];
    wheel_outcome_t outcome_q [$];
    int             busy_items = 0;
    int             fail_count = 0;
    int             cycle_count = 0;
    logic           in_taken = 1'b0;

    // Sender burst/gap and receiver pattern state
    int          send_burst = 1;
    int          send_gap = 0;
    logic [15:0] rdy_pattern = '1;
    int          rdy_phase = 0;
    int          rdy_life = 0;

    wheel_outcome_t got;
    wheel_outcome_t want;
    wheel_item_t    taken_item;
    wheel_item_t    next_item;

    // Apply one action to the table and work out the result it gives
    function automatic wheel_outcome_t apply_action(wheel_item_t s);
        wheel_outcome_t r;
        logic [47:0]    portion;
        logic [63:0]    prefix;
        logic [32:0]    sum;
        t_total         quot;
        logic           found;
        int unsigned    pick;
        r = '{default: '0};
        case (s.action)
            ACT_CLEAR: begin
                wheel_count = 0;
                wheel_total = '0;
                wheel_worst = '1;
                wheel_best  = '0;
            end
            ACT_APPEND: begin
                if (wheel_count < MAX_ENTRIES) begin
                    wheel_fit[wheel_count] = s.fitness;
                    wheel_count++;
                    sum = {1'b0, wheel_total} + {9'd0, s.fitness};
                    wheel_total = sum[32] ? '1 : sum[31:0];
                    if (s.fitness < wheel_worst) wheel_worst = s.fitness;
                    if (s.fitness > wheel_best) wheel_best = s.fitness;
                end else begin
                    r.status = STS_FULL;
                end
            end
            ACT_SELECT: begin
                if (wheel_count == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    // exact compare: prefix * 2^16 > fraction * total
                    portion = {32'd0, s.fraction} * {16'd0, wheel_total};
                    prefix  = '0;
                    found   = 1'b0;
                    pick    = 0;
                    for (int i = 0; i < wheel_count; i++) begin
                        prefix = prefix + {40'd0, wheel_fit[i]};
                        if (!found && ((prefix << 16) > {16'd0, portion})) begin
                            found = 1'b1;
                            pick  = i;
                        end
                    end
                    r.index    = t_idx_io'(pick);
                    r.pick_fit = wheel_fit[pick];
                end
            end
            default: begin
                // no-op code: nothing changes
            end
        endcase
        if (wheel_count != 0) begin
            quot  = wheel_total / t_total'(wheel_count);
            r.avg = quot[FIT_IO_W-1:0];
        end
        r.count = t_count_io'(wheel_count);
        r.total = wheel_total;
        r.worst = wheel_worst;
        r.best  = wheel_best;
        return r;
    endfunction

    task automatic queue_item(t_action a, t_fit_io f, t_frac r);
        wheel_item_t it;
        it.action   = a;
        it.fitness  = f;
        it.fraction = r;
        action_q.insert(action_q.size(), it);
        if (a != ACT_NOP) busy_items++;
    endtask

    function automatic t_fit_io pick_fitness(int vmode);
        case (vmode)
            0: return t_fit_io'($urandom);
            1: return t_fit_io'($urandom_range(0, 255));
            2: return '1;
            3: return ($urandom_range(0, 3) == 0) ? t_fit_io'($urandom) : '0;
            default: return t_fit_io'($urandom >> $urandom_range(8, 31));
        endcase
    endfunction

    function automatic t_frac pick_fraction();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return t_frac'($urandom);
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Input driver: bursts with random gaps, holds an item until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (send_gap != 0) begin
                in_ch.valid <= 1'b0;
                send_gap--;
            end else if (action_q.size() != 0) begin
                next_item = action_q.pop_front();
                in_ch.action          <= next_item.action;
                in_ch.fitness         <= next_item.fitness;
                in_ch.random_fraction <= next_item.fraction;
                in_ch.valid           <= 1'b1;
                if (send_burst > 1) begin
                    send_burst--;
                end else begin
                    send_burst = $urandom_range(1, 16);
                    send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: ready follows a rotating pattern, reloaded now and then
    always @(negedge i_clk) begin
        if (rdy_life == 0) begin
            case ($urandom_range(0, 3))
                0: rdy_pattern = '1;
                1: rdy_pattern = 16'h0001 << $urandom_range(0, 15);
                default: rdy_pattern = 16'($urandom) | 16'h0001;
            endcase
            rdy_life = $urandom_range(16, 200);
        end
        rdy_life--;
        out_ch.ready <= rdy_pattern[rdy_phase];
        rdy_phase = (rdy_phase + 1) % 16;
    end

    // Monitor: check results, then predict for items taken at this edge
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("roulette_wheel_selector regression: fail");
            $finish;
        end else begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result item with no expectation pending");
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    got.status   = out_ch.status;
                    got.index    = out_ch.selected_index;
                    got.pick_fit = out_ch.selected_fitness;
                    got.count    = out_ch.population_count;
                    got.total    = out_ch.total_fitness;
                    got.worst    = out_ch.worst_fitness;
                    got.best     = out_ch.best_fitness;
                    got.avg      = out_ch.average_fitness;
                    check_field("status", want.status, got.status);
                    check_field("selected_index", want.index, got.index);
                    check_field("selected_fitness", want.pick_fit, got.pick_fit);
                    check_field("population_count", want.count, got.count);
                    check_field("total_fitness", want.total, got.total);
                    check_field("worst_fitness", want.worst, got.worst);
                    check_field("best_fitness", want.best, got.best);
                    check_field("average_fitness", want.avg, got.avg);
                end
            end
            if (i_rst_n && in_ch.valid && in_ch.ready) begin
                taken_item.action   = t_action'(in_ch.action);
                taken_item.fitness  = in_ch.fitness;
                taken_item.fraction = in_ch.random_fraction;
                outcome_q.insert(outcome_q.size(), apply_action(taken_item));
            end
        end
    end

    initial begin
        int  vmode;
        int  n_app;
        int  sel_odds;
        int  target;
        bit  first;
        bit  full_run;

        in_ch.valid           = 1'b0;
        in_ch.action          = ACT_NOP;
        in_ch.fitness         = '0;
        in_ch.random_fraction = '0;
        out_ch.ready          = 1'b0;
        foreach (wheel_fit[i]) wheel_fit[i] = '0;

        // Directed: empty table, extremes, all-zero table, exact boundary
        queue_item(ACT_NOP, '1, '1);
        queue_item(ACT_SELECT, '0, '0);
        queue_item(ACT_APPEND, '1, '0);
        queue_item(ACT_APPEND, '0, '1);
        queue_item(ACT_APPEND, 24'd1, '0);
        queue_item(ACT_SELECT, '0, '0);
        queue_item(ACT_SELECT, '1, '1);
        queue_item(ACT_SELECT, '0, 16'h8000);
        queue_item(ACT_NOP, 24'h5A5A5A, 16'hA5A5);
        queue_item(ACT_CLEAR, '1, '1);
        queue_item(ACT_APPEND, '0, '0);
        queue_item(ACT_APPEND, '0, '0);
        queue_item(ACT_APPEND, '0, '0);
        queue_item(ACT_SELECT, '0, '1);
        queue_item(ACT_SELECT, '0, '0);
        queue_item(ACT_CLEAR, '0, '0);
        queue_item(ACT_SELECT, '1, 16'h1234);
        // prefix*2^16 equal to the portion does not qualify: picks the second
        queue_item(ACT_APPEND, 24'd1, '0);
        queue_item(ACT_APPEND, 24'd1, '0);
        queue_item(ACT_SELECT, '0, 16'h8000);
        queue_item(ACT_SELECT, '0, 16'h7FFF);
        queue_item(ACT_CLEAR, '0, '0);
        queue_item(ACT_APPEND, 24'd5, '0);
        queue_item(ACT_SELECT, '0, '1);

        // Random runs: usually a clear, appends with selects and no-ops woven in, then selects.
        // The first run fills the table with the largest value and may overflow it.
        target = busy_items + RANDOM_ITEMS;
        first  = 1'b1;
        while (busy_items < target) begin
            full_run = first || ($urandom_range(0, 9) == 0);
            vmode    = first ? 2 : $urandom_range(0, 4);
            if (first || $urandom_range(0, 5) != 0)
                queue_item(ACT_CLEAR, t_fit_io'($urandom), t_frac'($urandom));
            if ($urandom_range(0, 4) == 0)
                queue_item(ACT_SELECT, t_fit_io'($urandom), pick_fraction());
            n_app    = full_run ? $urandom_range(256, 262) : $urandom_range(1, 24);
            sel_odds = full_run ? 8 : 3;
            for (int k = 0; k < n_app; k++) begin
                queue_item(ACT_APPEND, pick_fitness(vmode), t_frac'($urandom));
                if ($urandom_range(0, sel_odds - 1) == 0)
                    queue_item(ACT_SELECT, t_fit_io'($urandom), pick_fraction());
                if ($urandom_range(0, 19) == 0)
                    queue_item(ACT_NOP, t_fit_io'($urandom), t_frac'($urandom));
            end
            repeat ($urandom_range(2, 8))
                queue_item(ACT_SELECT, t_fit_io'($urandom), pick_fraction());
            first = 1'b0;
        end

        // Hold reset, then release it on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all items sent and taken, then all results in
        @(negedge i_clk);
        while (action_q.size() != 0 || in_ch.valid) @(negedge i_clk);
        while (outcome_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("roulette_wheel_selector regression: pass");
        end else begin
            $display("roulette_wheel_selector regression: fail");
        end
        $finish;
    end

endmodule
